// ----- hw/rtl/mcet_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcet_pkg
// Shared types and codes for the multi-channel event timer.
// ----------------------------------------------------------------------------
package mcet_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int CNT_W        = 32;
  localparam int MASK_W       = 8;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] target;
    logic [CNT_W-1:0] count;
    logic             running;
    logic             action;
  } mcet_entry_t;

  typedef struct packed {
    logic              valid;
    logic              accepted;
    logic [MASK_W-1:0] mask;
  } mcet_result_t;

endpackage

// ----- hw/rtl/mcet_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcet_mem
// Channel table: one write port, one read port, registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module mcet_mem
  import mcet_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  mcet_entry_t      wr_data,
  output mcet_entry_t      rd_data
);

  mcet_entry_t mem [CHANNELS];
  logic [CHANNELS-1:0] vld;
  mcet_entry_t         mem_q;
  logic                vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule

// ----- hw/rtl/mcet_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcet_ctrl
// Command sequencer: decodes commands, walks the table on tick with a
// read-modify-write per channel, and builds the result.
// ----------------------------------------------------------------------------
module mcet_ctrl
  import mcet_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [5:0]         channel,
  input  logic [CNT_W-1:0]   target,
  input  logic               has_action,
  input  logic               run_flag,
  output logic               rd_en,
  output logic [IDX_W-1:0]   rd_addr,
  output logic               wr_en,
  output logic [IDX_W-1:0]   wr_addr,
  output mcet_entry_t        wr_data,
  input  mcet_entry_t        rd_data,
  input  logic               res_free,
  output mcet_result_t       res
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_WALK    = 4'b0010,
    ST_STOP_WR = 4'b0100,
    ST_DONE    = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  state_t            state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [MASK_W-1:0] mask, mask_next;
  logic              res_acc, res_acc_next;
  logic              ch_ok;
  logic              hit;
  mcet_entry_t       upd;

  assign ch_ok    = {26'd0, channel} < 32'(CHANNELS);
  assign in_stall = (state != ST_IDLE);
  assign hit      = rd_data.count >= rd_data.target;

  always_comb begin
    upd = rd_data;
    if (rd_data.running) begin
      upd.count = hit ? '0 : rd_data.count + 1'b1;
    end
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    mask_next    = mask;
    res_acc_next = res_acc;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = idx;
    wr_data      = upd;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          mask_next = '0;
          case (command)
            CMD_TICK: begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              idx_next   = '0;
              state_next = ST_WALK;
            end
            CMD_SET: begin
              wr_en           = ch_ok;
              wr_addr         = channel[IDX_W-1:0];
              wr_data.target  = target;
              wr_data.count   = '0;
              wr_data.running = run_flag;
              wr_data.action  = has_action;
              res_acc_next    = ch_ok;
              state_next      = ST_DONE;
            end
            CMD_STOP: begin
              if (ch_ok) begin
                rd_en      = 1'b1;
                rd_addr    = channel[IDX_W-1:0];
                idx_next   = channel[IDX_W-1:0];
                state_next = ST_STOP_WR;
              end else begin
                res_acc_next = 1'b0;
                state_next   = ST_DONE;
              end
            end
            default: begin
              res_acc_next = 1'b0;
              state_next   = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK: begin
        wr_en = 1'b1;
        if (rd_data.running && hit && rd_data.action) begin
          mask_next = mask | (MASK_W'(1) << idx);
        end
        if (idx == LAST_IDX) begin
          res_acc_next = 1'b1;
          state_next   = ST_DONE;
        end else begin
          idx_next   = idx + 1'b1;
          rd_en      = 1'b1;
          rd_addr    = idx + 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_STOP_WR: begin
        wr_en           = 1'b1;
        wr_data         = rd_data;
        wr_data.count   = '0;
        wr_data.running = 1'b0;
        res_acc_next    = 1'b1;
        state_next      = ST_DONE;
      end
      ST_DONE: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      idx     <= '0;
      mask    <= '0;
      res_acc <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      mask    <= mask_next;
      res_acc <= res_acc_next;
    end
  end

  assign res.valid    = (state == ST_DONE);
  assign res.accepted = res_acc;
  assign res.mask     = mask;

endmodule

// ----- hw/rtl/multi_channel_event_timer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_event_timer_unit
// One item in flight: a tick walks every channel, a stop reads its channel and
// writes it back, set and refused commands go straight to the result. The
// next item is accepted in the cycle after the result is loaded. Tick time is
// set by the table walk, one memory read-modify-write per channel per cycle.
// Reset clears the sequencer, output valid and table valid bits (all
// channels read as zero, stopped); no clearing pass.
// ----------------------------------------------------------------------------
module multi_channel_event_timer_unit
  import mcet_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [5:0]        channel,
  input  logic [CNT_W-1:0]  target,
  input  logic              has_action,
  input  logic              run_flag,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              accepted,
  output logic [MASK_W-1:0] fired_mask
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  mcet_entry_t      wr_data;
  mcet_entry_t      rd_data;
  mcet_result_t     res;
  logic             res_free;

  mcet_ctrl #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .channel    (channel),
    .target     (target),
    .has_action (has_action),
    .run_flag   (run_flag),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_data    (rd_data),
    .res_free   (res_free),
    .res        (res)
  );

  mcet_mem #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // output register
  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_free) begin
      accepted   <= res.accepted;
      fired_mask <= res.mask;
    end
  end

endmodule

// ----- hw/rtl/mcet_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcet_checker
// Port-level checks for the event timer, bound to the top level.
// ----------------------------------------------------------------------------
module mcet_checker
  import mcet_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              accepted,
  input logic [MASK_W-1:0] fired_mask
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transfer dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(accepted) && $stable(fired_mask))
    else $error("output payload changed while stalled");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before result built");

  a_refused_no_fire: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> fired_mask == '0)
    else $error("refused command reported fired channels");

  a_mask_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fired_mask >> CHANNELS) == '0)
    else $error("fired bit for nonexistent channel");

endmodule

bind multi_channel_event_timer_unit mcet_checker #(
  .CHANNELS (CHANNELS)
) u_mcet_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .accepted   (accepted),
  .fired_mask (fired_mask)
);
